### rtl/afb_pkg.sv
`default_nettype none
package afb_pkg;

  localparam int ALLOWED_DEPTH = 128;
  localparam int BLOCKED_ADDR_DEPTH = 1024;
  localparam int BLOCKED_PORT_DEPTH = 128;

  localparam int AL_AW = (ALLOWED_DEPTH > 1) ? $clog2(ALLOWED_DEPTH) : 1;
  localparam int BA_AW = (BLOCKED_ADDR_DEPTH > 1) ? $clog2(BLOCKED_ADDR_DEPTH) : 1;
  localparam int BP_AW = (BLOCKED_PORT_DEPTH > 1) ? $clog2(BLOCKED_PORT_DEPTH) : 1;

  localparam int MAX_DEPTH0 = (ALLOWED_DEPTH > BLOCKED_ADDR_DEPTH) ?
                              ALLOWED_DEPTH : BLOCKED_ADDR_DEPTH;
  localparam int MAX_DEPTH = (MAX_DEPTH0 > BLOCKED_PORT_DEPTH) ?
                             MAX_DEPTH0 : BLOCKED_PORT_DEPTH;
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [IDX_W-1:0] CLEAR_LAST = IDX_W'(MAX_DEPTH - 1);
  localparam logic [IDX_W-1:0] AL_LAST = IDX_W'(ALLOWED_DEPTH - 1);
  localparam logic [IDX_W-1:0] BA_LAST = IDX_W'(BLOCKED_ADDR_DEPTH - 1);
  localparam logic [IDX_W-1:0] BP_LAST = IDX_W'(BLOCKED_PORT_DEPTH - 1);
  localparam logic [IDX_W:0] AL_LIM = (IDX_W + 1)'(ALLOWED_DEPTH);
  localparam logic [IDX_W:0] BA_LIM = (IDX_W + 1)'(BLOCKED_ADDR_DEPTH);
  localparam logic [IDX_W:0] BP_LIM = (IDX_W + 1)'(BLOCKED_PORT_DEPTH);

  localparam int ADDR_ENTRY_W = 33;
  localparam int PORT_ENTRY_W = 17;

  localparam logic [2:0] CMD_PACKET = 3'd0;
  localparam logic [2:0] CMD_ADD_ALLOW = 3'd1;
  localparam logic [2:0] CMD_DEL_ALLOW = 3'd2;
  localparam logic [2:0] CMD_ADD_BADDR = 3'd3;
  localparam logic [2:0] CMD_DEL_BADDR = 3'd4;
  localparam logic [2:0] CMD_ADD_BPORT = 3'd5;
  localparam logic [2:0] CMD_DEL_BPORT = 3'd6;
  localparam logic [2:0] CMD_READ_CNT = 3'd7;

  localparam logic [2:0] REASON_NOT_IPV4 = 3'd0;
  localparam logic [2:0] REASON_ALLOW = 3'd1;
  localparam logic [2:0] REASON_BLOCK_IP = 3'd2;
  localparam logic [2:0] REASON_NO_PORTS = 3'd3;
  localparam logic [2:0] REASON_BLOCK_PORT = 3'd4;
  localparam logic [2:0] REASON_DEFAULT = 3'd5;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  localparam int NUM_COUNTERS = 7;
  localparam int CNT_TOTAL = 0;
  localparam int CNT_DROP = 1;
  localparam int CNT_ACCEPT = 2;
  localparam int CNT_TCP = 3;
  localparam int CNT_UDP = 4;
  localparam int CNT_ICMP = 5;
  localparam int CNT_OTHER = 6;
  localparam logic [2:0] CNT_LAST_IDX = 3'(NUM_COUNTERS - 1);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [3:0] IP_V4 = 4'd4;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam logic [1:0] PCL_TCP = 2'd0;
  localparam logic [1:0] PCL_UDP = 2'd1;
  localparam logic [1:0] PCL_ICMP = 2'd2;
  localparam logic [1:0] PCL_OTHER = 2'd3;

  localparam logic [1:0] TBL_ALLOW = 2'd0;
  localparam logic [1:0] TBL_BADDR = 2'd1;
  localparam logic [1:0] TBL_BPORT = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] eth_type;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        ports_present;
    logic [31:0] key;
    logic [2:0]  counter_index;
  } in_t;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  reason;
    logic        counted;
    logic [1:0]  status;
    logic [63:0] counter_value;
  } out_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        ipv4_ok;
    logic        port_check;
    logic [1:0]  pclass;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] key;
    logic [2:0]  counter_index;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOW,
    ST_BADDR,
    ST_PORT,
    ST_TABLE,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

### rtl/afb_ram.sv
`default_nettype none
module afb_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/afb_front.sv
`default_nettype none
module afb_front (
  input  wire logic          in_valid,
  input  wire afb_pkg::in_t  in_data,
  output logic               in_stall,
  input  wire afb_pkg::q_stat_t q_stat,
  output logic               push,
  output afb_pkg::job_t      job
);

  always_comb begin
    in_stall = q_stat.full;
    push = in_valid && !q_stat.full;

    job.cmd = in_data.cmd;
    job.ipv4_ok = (in_data.eth_type == afb_pkg::ETH_IPV4) &&
                  (in_data.ip_version == afb_pkg::IP_V4) &&
                  (in_data.header_words >= afb_pkg::MIN_HDR_WORDS);
    job.port_check = (in_data.protocol == afb_pkg::PROTO_TCP) ||
                     (in_data.protocol == afb_pkg::PROTO_UDP);
    if (in_data.protocol == afb_pkg::PROTO_TCP) begin
      job.pclass = afb_pkg::PCL_TCP;
    end else if (in_data.protocol == afb_pkg::PROTO_UDP) begin
      job.pclass = afb_pkg::PCL_UDP;
    end else if (in_data.protocol == afb_pkg::PROTO_ICMP) begin
      job.pclass = afb_pkg::PCL_ICMP;
    end else begin
      job.pclass = afb_pkg::PCL_OTHER;
    end
    job.src_ip = in_data.src_ip;
    job.dst_ip = in_data.dst_ip;
    job.sport = in_data.ports_present ? in_data.sport : 16'd0;
    job.dport = in_data.ports_present ? in_data.dport : 16'd0;
    // port commands key on the low half only
    if (in_data.cmd == afb_pkg::CMD_ADD_BPORT || in_data.cmd == afb_pkg::CMD_DEL_BPORT) begin
      job.key = {16'd0, in_data.key[15:0]};
    end else begin
      job.key = in_data.key;
    end
    job.counter_index = in_data.counter_index;
  end

endmodule
`default_nettype wire

### rtl/afb_queue.sv
`default_nettype none
module afb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire afb_pkg::job_t wdata,
  input  wire logic          pop,
  output afb_pkg::job_t      rdata,
  output afb_pkg::q_stat_t   q_stat
);

  afb_pkg::job_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

  always_comb begin
    rdata = slot[rptr];
    q_stat.full = (count == 2'd2);
    q_stat.empty = (count == 2'd0);
  end

endmodule
`default_nettype wire

### rtl/afb_back.sv
`default_nettype none
module afb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire afb_pkg::q_stat_t q_stat,
  input  wire afb_pkg::job_t    q_rdata,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output afb_pkg::out_t         out_data
);

  afb_pkg::state_t state;
  afb_pkg::state_t state_next;
  afb_pkg::job_t   job;
  logic [afb_pkg::IDX_W-1:0] idx;
  logic [afb_pkg::IDX_W-1:0] idx_q;
  logic [afb_pkg::IDX_W-1:0] free_idx;
  logic                      rdv;
  logic                      issue_done;
  logic                      free_found;
  logic [63:0] cnt [afb_pkg::NUM_COUNTERS];

  logic [afb_pkg::ADDR_ENTRY_W-1:0] al_rdata;
  logic [afb_pkg::ADDR_ENTRY_W-1:0] ba_rdata;
  logic [afb_pkg::PORT_ENTRY_W-1:0] bp_rdata;

  logic [1:0]  tsel;
  logic [afb_pkg::IDX_W-1:0] last;
  logic        ent_valid;
  logic [31:0] ent_key;
  logic        hit;
  logic        scan_end;
  logic        is_add;
  logic        free_any;
  logic        wr_en;
  logic [afb_pkg::IDX_W-1:0] wr_idx;
  logic        wr_valid;
  logic        al_we;
  logic        ba_we;
  logic        bp_we;
  logic        finish;
  afb_pkg::out_t res;
  logic [afb_pkg::NUM_COUNTERS-1:0] inc;

  afb_ram #(.WIDTH(afb_pkg::ADDR_ENTRY_W), .DEPTH(afb_pkg::ALLOWED_DEPTH)) u_al_ram (
    .clk(clk), .we(al_we), .waddr(wr_idx[afb_pkg::AL_AW-1:0]),
    .wdata({wr_valid, job.key}), .raddr(idx[afb_pkg::AL_AW-1:0]), .rdata(al_rdata)
  );

  afb_ram #(.WIDTH(afb_pkg::ADDR_ENTRY_W), .DEPTH(afb_pkg::BLOCKED_ADDR_DEPTH)) u_ba_ram (
    .clk(clk), .we(ba_we), .waddr(wr_idx[afb_pkg::BA_AW-1:0]),
    .wdata({wr_valid, job.key}), .raddr(idx[afb_pkg::BA_AW-1:0]), .rdata(ba_rdata)
  );

  afb_ram #(.WIDTH(afb_pkg::PORT_ENTRY_W), .DEPTH(afb_pkg::BLOCKED_PORT_DEPTH)) u_bp_ram (
    .clk(clk), .we(bp_we), .waddr(wr_idx[afb_pkg::BP_AW-1:0]),
    .wdata({wr_valid, job.key[15:0]}), .raddr(idx[afb_pkg::BP_AW-1:0]), .rdata(bp_rdata)
  );

  // table select and entry compare
  always_comb begin
    is_add = (job.cmd == afb_pkg::CMD_ADD_ALLOW) || (job.cmd == afb_pkg::CMD_ADD_BADDR) ||
             (job.cmd == afb_pkg::CMD_ADD_BPORT);
    case (state)
      afb_pkg::ST_BADDR: tsel = afb_pkg::TBL_BADDR;
      afb_pkg::ST_PORT:  tsel = afb_pkg::TBL_BPORT;
      afb_pkg::ST_TABLE: begin
        if (job.cmd == afb_pkg::CMD_ADD_BADDR || job.cmd == afb_pkg::CMD_DEL_BADDR) begin
          tsel = afb_pkg::TBL_BADDR;
        end else if (job.cmd == afb_pkg::CMD_ADD_BPORT ||
                     job.cmd == afb_pkg::CMD_DEL_BPORT) begin
          tsel = afb_pkg::TBL_BPORT;
        end else begin
          tsel = afb_pkg::TBL_ALLOW;
        end
      end
      default: tsel = afb_pkg::TBL_ALLOW;
    endcase
    case (tsel)
      afb_pkg::TBL_BADDR: begin
        last = afb_pkg::BA_LAST;
        ent_valid = ba_rdata[32];
        ent_key = ba_rdata[31:0];
      end
      afb_pkg::TBL_BPORT: begin
        last = afb_pkg::BP_LAST;
        ent_valid = bp_rdata[16];
        ent_key = {16'd0, bp_rdata[15:0]};
      end
      default: begin
        last = afb_pkg::AL_LAST;
        ent_valid = al_rdata[32];
        ent_key = al_rdata[31:0];
      end
    endcase
    case (state)
      afb_pkg::ST_ALLOW, afb_pkg::ST_BADDR:
        hit = rdv && ent_valid && (ent_key == job.src_ip || ent_key == job.dst_ip);
      afb_pkg::ST_PORT:
        hit = rdv && ent_valid &&
              (ent_key[15:0] == job.sport || ent_key[15:0] == job.dport);
      afb_pkg::ST_TABLE:
        hit = rdv && ent_valid && (ent_key == job.key);
      default: hit = 1'b0;
    endcase
    scan_end = rdv && (idx_q == last);
    free_any = free_found || (rdv && !ent_valid);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      afb_pkg::ST_CLEAR: begin
        if (idx == afb_pkg::CLEAR_LAST) begin
          state_next = afb_pkg::ST_IDLE;
        end
      end
      afb_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          case (q_rdata.cmd)
            afb_pkg::CMD_PACKET:
              state_next = q_rdata.ipv4_ok ? afb_pkg::ST_ALLOW : afb_pkg::ST_RESP;
            afb_pkg::CMD_READ_CNT: state_next = afb_pkg::ST_RESP;
            default: state_next = afb_pkg::ST_TABLE;
          endcase
        end
      end
      afb_pkg::ST_ALLOW: begin
        if (hit) begin
          state_next = afb_pkg::ST_RESP;
        end else if (scan_end) begin
          state_next = afb_pkg::ST_BADDR;
        end
      end
      afb_pkg::ST_BADDR: begin
        if (hit) begin
          state_next = afb_pkg::ST_RESP;
        end else if (scan_end) begin
          state_next = job.port_check ? afb_pkg::ST_PORT : afb_pkg::ST_RESP;
        end
      end
      afb_pkg::ST_PORT, afb_pkg::ST_TABLE: begin
        if (hit || scan_end) begin
          state_next = afb_pkg::ST_RESP;
        end
      end
      afb_pkg::ST_RESP: begin
        if (!out_stall) begin
          state_next = afb_pkg::ST_IDLE;
        end
      end
      default: state_next = afb_pkg::ST_IDLE;
    endcase
  end

  // outputs and result
  always_comb begin
    pop = (state == afb_pkg::ST_IDLE) && !q_stat.empty;
    out_valid = (state == afb_pkg::ST_RESP);
    finish = (state != afb_pkg::ST_RESP) && (state_next == afb_pkg::ST_RESP);

    wr_en = 1'b0;
    wr_idx = idx_q;
    wr_valid = 1'b0;
    case (state)
      afb_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_idx = idx;
      end
      afb_pkg::ST_TABLE: begin
        if (is_add) begin
          wr_en = scan_end && !hit && free_any;
          wr_idx = free_found ? free_idx : idx_q;
          wr_valid = 1'b1;
        end else begin
          wr_en = hit;
        end
      end
      default: wr_en = 1'b0;
    endcase
    al_we = wr_en && (state == afb_pkg::ST_CLEAR ? ({1'b0, wr_idx} < afb_pkg::AL_LIM)
                                                 : (tsel == afb_pkg::TBL_ALLOW));
    ba_we = wr_en && (state == afb_pkg::ST_CLEAR ? ({1'b0, wr_idx} < afb_pkg::BA_LIM)
                                                 : (tsel == afb_pkg::TBL_BADDR));
    bp_we = wr_en && (state == afb_pkg::ST_CLEAR ? ({1'b0, wr_idx} < afb_pkg::BP_LIM)
                                                 : (tsel == afb_pkg::TBL_BPORT));

    res = '0;
    case (state)
      afb_pkg::ST_IDLE: begin
        if (q_rdata.cmd == afb_pkg::CMD_READ_CNT &&
            q_rdata.counter_index <= afb_pkg::CNT_LAST_IDX) begin
          res.counter_value = cnt[q_rdata.counter_index];
        end
      end
      afb_pkg::ST_ALLOW: begin
        res.counted = 1'b1;
        res.reason = afb_pkg::REASON_ALLOW;
      end
      afb_pkg::ST_BADDR: begin
        res.counted = 1'b1;
        res.verdict = hit;
        res.reason = hit ? afb_pkg::REASON_BLOCK_IP : afb_pkg::REASON_NO_PORTS;
      end
      afb_pkg::ST_PORT: begin
        res.counted = 1'b1;
        res.verdict = hit;
        res.reason = hit ? afb_pkg::REASON_BLOCK_PORT : afb_pkg::REASON_DEFAULT;
      end
      afb_pkg::ST_TABLE: begin
        if (hit) begin
          res.status = afb_pkg::STATUS_OK;
        end else if (is_add) begin
          res.status = free_any ? afb_pkg::STATUS_OK : afb_pkg::STATUS_FULL;
        end else begin
          res.status = afb_pkg::STATUS_ABSENT;
        end
      end
      default: res = '0;
    endcase

    inc = '0;
    inc[afb_pkg::CNT_TOTAL] = 1'b1;
    inc[afb_pkg::CNT_DROP] = res.verdict;
    inc[afb_pkg::CNT_ACCEPT] = !res.verdict;
    inc[afb_pkg::CNT_TCP] = (job.pclass == afb_pkg::PCL_TCP);
    inc[afb_pkg::CNT_UDP] = (job.pclass == afb_pkg::PCL_UDP);
    inc[afb_pkg::CNT_ICMP] = (job.pclass == afb_pkg::PCL_ICMP);
    inc[afb_pkg::CNT_OTHER] = (job.pclass == afb_pkg::PCL_OTHER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afb_pkg::ST_CLEAR;
      idx <= '0;
      rdv <= 1'b0;
      issue_done <= 1'b0;
      free_found <= 1'b0;
      for (int i = 0; i < afb_pkg::NUM_COUNTERS; i++) begin
        cnt[i] <= 64'd0;
      end
    end else begin
      state <= state_next;
      if (state == afb_pkg::ST_CLEAR) begin
        idx <= (idx == afb_pkg::CLEAR_LAST) ? '0 : idx + 1'b1;
      end else if (state_next != state) begin
        idx <= '0;
        rdv <= 1'b0;
        issue_done <= 1'b0;
        free_found <= 1'b0;
      end else if (state == afb_pkg::ST_ALLOW || state == afb_pkg::ST_BADDR ||
                   state == afb_pkg::ST_PORT || state == afb_pkg::ST_TABLE) begin
        rdv <= !issue_done;
        if (!issue_done) begin
          if (idx == last) begin
            issue_done <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        if (rdv && !ent_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (finish && res.counted) begin
        for (int i = 0; i < afb_pkg::NUM_COUNTERS; i++) begin
          cnt[i] <= cnt[i] + 64'(inc[i]);
        end
      end
    end
    idx_q <= idx;
    if (rdv && !ent_valid && !free_found) begin
      free_idx <= idx_q;
    end
    if (pop) begin
      job <= q_rdata;
    end
    if (finish) begin
      out_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.counted |-> out_data.reason != afb_pkg::REASON_NOT_IPV4)
    else $error("counted beat without classification");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.verdict |->
      (out_data.reason == afb_pkg::REASON_BLOCK_IP ||
       out_data.reason == afb_pkg::REASON_BLOCK_PORT))
    else $error("drop with non-blocking reason");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != afb_pkg::STATUS_OK |->
      !out_data.verdict && !out_data.counted && out_data.reason == afb_pkg::REASON_NOT_IPV4)
    else $error("table status on packet beat");

  assert property (@(posedge clk) disable iff (rst)
    (state == afb_pkg::ST_RESP) && ($past(state) != afb_pkg::ST_RESP) && out_data.counted |->
      cnt[afb_pkg::CNT_TOTAL] == $past(cnt[afb_pkg::CNT_TOTAL]) + 64'd1)
    else $error("total counter not bumped");

endmodule
`default_nettype wire

### rtl/ipv4_allow_block_filter_core.sv
// Scans: a table command scans one table; a packet scans the allow, blocked-address
//   and, for TCP/UDP, blocked-port tables in turn, one entry per cycle, through the
//   table RAMs' single read port. Counter reads and non-IPv4 frames skip the scans.
// Flow: one beat is finished before the next; a two-entry queue takes input meanwhile.
// Reset: synchronous; clears counters, then sweeps all tables invalid over the index
//   range of the largest table depth before the first beat is processed.
`default_nettype none
module ipv4_allow_block_filter_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire afb_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output afb_pkg::out_t     out_data
);

  afb_pkg::q_stat_t q_stat;
  afb_pkg::job_t    push_job;
  afb_pkg::job_t    q_rdata;
  logic             push;
  logic             pop;

  afb_front u_front (
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .q_stat(q_stat), .push(push), .job(push_job)
  );

  afb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(push_job),
    .pop(pop), .rdata(q_rdata), .q_stat(q_stat)
  );

  afb_back u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .q_rdata(q_rdata), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
`default_nettype wire
